[hw/rtl/ddrg_pkg.sv]
// Package for the dedup deadline relay gate: transaction structs, event codes,
// register indexes and fixed constants.
// No dependencies.
package ddrg_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_DEFAULT_DURATION = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RELAY_ACTIVE_LOW = 2'd1;

	localparam logic CMD_RELEASE = 1'b0;
	localparam logic CMD_TICK    = 1'b1;

	localparam logic [31:0] CLOCK_SYNC_EPOCH       = 32'd1700000000;
	localparam logic [31:0] DEFAULT_DURATION_RESET = 32'd5000;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_RELEASED  = 3'd1,
		EV_DUPLICATE = 3'd2,
		EV_EXPIRED   = 3'd3,
		EV_TIMEOUT   = 3'd4
	} event_t;

	typedef struct packed {
		logic        cmd;
		logic [63:0] msg_id_high;
		logic [63:0] msg_id_low;
		logic        msg_id_present;
		logic        deadline_present;
		logic [31:0] deadline_epoch;
		logic [31:0] now_epoch;
		logic        duration_present;
		logic [31:0] duration_ms;
		logic [63:0] verification_tag;
	} item_t;

	typedef struct packed {
		event_t      event_res;
		logic        relay_level;
		logic        lamp_on;
		logic [63:0] event_tag;
		logic        deadline_unchecked;
	} result_t;

	typedef struct packed {
		logic start;
		logic present;
	} seen_req_t;

	typedef struct packed {
		logic done;
		logic dup;
	} seen_rsp_t;

endpackage

[hw/rtl/dedup_deadline_relay_gate.sv]
// Top level of the dedup deadline relay gate: command control, deadline check,
// relay window timer and configuration. Depends on ddrg_pkg, ddrg_seen.
//
//   channel   handshake          payload      notes
//   input     start / busy       item         accepted when start and not busy
//   result    done               result       a single-cycle done per result, no stall
//   config    cfg_we             cfg_index,   written at once, no read-back
//                                cfg_wdata
//
// A tick's result is registered and appears in the cycle after acceptance; busy stays low.
// A release scans the identifier ring one RAM entry per cycle, with busy high while it
// waits for the ring; a release without an identifier skips the scan, and its result
// passes through the ring's done register and then the top's result register.
// Reset is asynchronous; it clears the ring valid bits and window state and sets the config registers to defaults.
// The receiver cannot stall; every result transaction is taken when done is high.
module dedup_deadline_relay_gate import ddrg_pkg::*; #(
	parameter int SEEN_DEPTH = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  item_t                  item,
	output logic                   done,
	output result_t                result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	typedef enum logic {C_IDLE, C_WAIT} state_t;

	state_t      state_q;
	item_t       item_q;
	logic [31:0] default_dur_q;
	logic        active_low_q;
	logic        open_q;
	logic [31:0] close_q;
	logic [31:0] ms_q;
	logic [63:0] wtag_q;
	logic        done_q;
	result_t     result_q;

	seen_req_t   seen_req;
	seen_rsp_t   seen_rsp;
	logic        accept;
	logic [31:0] ms_next;
	logic [31:0] elapsed;
	logic        expire;
	logic        unchk;
	logic        expired;
	logic [31:0] len;

	assign accept           = start && (state_q == C_IDLE);
	assign seen_req.start   = accept && (item.cmd == CMD_RELEASE);
	assign seen_req.present = item.msg_id_present;

	assign ms_next = ms_q + 32'd1;
	assign elapsed = ms_next - close_q;
	assign expire  = open_q && !elapsed[31];

	assign unchk   = item_q.deadline_present &&
		((item_q.deadline_epoch == 32'd0) || (item_q.now_epoch <= CLOCK_SYNC_EPOCH));
	assign expired = item_q.deadline_present && !unchk &&
		(item_q.deadline_epoch < item_q.now_epoch);
	assign len     = item_q.duration_present ? item_q.duration_ms : default_dur_q;

	ddrg_seen #(
		.SEEN_DEPTH(SEEN_DEPTH)
	) u_seen (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (seen_req),
		.id_high(item_q.msg_id_high),
		.id_low (item_q.msg_id_low),
		.rsp    (seen_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_dur_q <= DEFAULT_DURATION_RESET;
			active_low_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEFAULT_DURATION: default_dur_q <= cfg_wdata;
				REG_RELAY_ACTIVE_LOW: active_low_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= C_IDLE;
			open_q   <= 1'b0;
			close_q  <= '0;
			ms_q     <= '0;
			wtag_q   <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_TICK) begin
							ms_q                        <= ms_next;
							done_q                      <= 1'b1;
							result_q.relay_level        <= (open_q && !expire) ^ active_low_q;
							result_q.lamp_on            <= open_q && !expire;
							result_q.deadline_unchecked <= 1'b0;
							if (expire) begin
								open_q             <= 1'b0;
								result_q.event_res <= EV_TIMEOUT;
								result_q.event_tag <= wtag_q;
							end else begin
								result_q.event_res <= EV_NONE;
								result_q.event_tag <= '0;
							end
						end else begin
							state_q <= C_WAIT;
						end
					end
				end
				C_WAIT: begin
					if (seen_rsp.done) begin
						state_q <= C_IDLE;
						done_q  <= 1'b1;
						if (seen_rsp.dup) begin
							result_q.event_res          <= EV_DUPLICATE;
							result_q.relay_level        <= open_q ^ active_low_q;
							result_q.lamp_on            <= open_q;
							result_q.event_tag          <= '0;
							result_q.deadline_unchecked <= 1'b0;
						end else if (expired) begin
							result_q.event_res          <= EV_EXPIRED;
							result_q.relay_level        <= open_q ^ active_low_q;
							result_q.lamp_on            <= open_q;
							result_q.event_tag          <= '0;
							result_q.deadline_unchecked <= 1'b0;
						end else begin
							open_q                      <= 1'b1;
							close_q                     <= ms_q + len;
							wtag_q                      <= item_q.verification_tag;
							result_q.event_res          <= EV_RELEASED;
							result_q.relay_level        <= ~active_low_q;
							result_q.lamp_on            <= 1'b1;
							result_q.event_tag          <= item_q.verification_tag;
							result_q.deadline_unchecked <= unchk;
						end
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q == C_WAIT);
	assign done   = done_q;
	assign result = result_q;

endmodule

[hw/rtl/ddrg_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module ddrg_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 20,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/ddrg_seen.sv]
// Ring of recently seen message identifiers: scans the RAM one entry per cycle
// for a duplicate and records new identifiers. Depends on ddrg_pkg, ddrg_ram.
module ddrg_seen import ddrg_pkg::*; #(
	parameter int SEEN_DEPTH = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  seen_req_t   req,
	input  logic [63:0] id_high,
	input  logic [63:0] id_low,
	output seen_rsp_t   rsp
);

	localparam int IW = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SEEN_DEPTH - 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN} state_t;

	state_t                state_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         idx_s1;
	logic                  rd_vld_s1;
	logic [IW-1:0]         ptr_q;
	logic [SEEN_DEPTH-1:0] valid_q;
	logic                  hit_q;
	logic                  done_q;
	logic                  dup_q;
	logic [127:0]          rdata;
	logic                  match;
	logic                  hit_final;
	logic                  ram_we;
	logic                  ram_re;
	logic [IW-1:0]         ptr_next;

	assign match     = rd_vld_s1 && valid_q[idx_s1] && (rdata == {id_high, id_low});
	assign hit_final = hit_q | match;
	assign ram_re    = (state_q == S_SCAN);
	assign ram_we    = (state_q == S_DRAIN) && !hit_final;
	assign ptr_next  = (ptr_q == LAST_IDX) ? '0 : ptr_q + IW'(1);

	ddrg_ram #(
		.WIDTH(128),
		.DEPTH(SEEN_DEPTH),
		.AW   (IW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q),
		.wdata({id_high, id_low}),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			idx_s1    <= '0;
			rd_vld_s1 <= 1'b0;
			ptr_q     <= '0;
			valid_q   <= '0;
			hit_q     <= 1'b0;
			done_q    <= 1'b0;
			dup_q     <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			idx_s1    <= idx_q;
			rd_vld_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (req.start) begin
						if (req.present) begin
							idx_q   <= '0;
							hit_q   <= 1'b0;
							state_q <= S_SCAN;
						end else begin
							valid_q[ptr_q] <= 1'b0;
							ptr_q          <= ptr_next;
							done_q         <= 1'b1;
							dup_q          <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					hit_q <= hit_final;
					if (idx_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_DRAIN: begin
					if (!hit_final) begin
						valid_q[ptr_q] <= 1'b1;
						ptr_q          <= ptr_next;
					end
					done_q  <= 1'b1;
					dup_q   <= hit_final;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.dup  = dup_q;

endmodule

[hw/rtl/ddrg_checker.sv]
// Port-level checker for the dedup deadline relay gate, bound to the top level.
// Depends on ddrg_pkg and dedup_deadline_relay_gate.
module ddrg_checker import ddrg_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    done,
	input result_t result
);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result transaction while busy");

	a_tick_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.cmd == CMD_TICK)) |=> (done && !busy))
		else $error("tick transaction did not complete in one cycle");

	a_release_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.event_res == EV_RELEASED)) |-> result.lamp_on)
		else $error("released event with the window closed");

	a_timeout_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.event_res == EV_TIMEOUT)) |-> !result.lamp_on)
		else $error("timeout event with the window open");

	a_unchecked_only_release: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.deadline_unchecked) |-> (result.event_res == EV_RELEASED))
		else $error("deadline flag on an event other than release");

endmodule

bind dedup_deadline_relay_gate ddrg_checker u_ddrg_checker (.*);

[test/dedup_deadline_relay_gate_test.sv]
// Self-checking testbench for dedup_deadline_relay_gate: directed and random commands and ticks,
// checked field by field against an in-bench model of the dedup ring and the relay window.
// Depends on ddrg_pkg and the dedup_deadline_relay_gate RTL.
`timescale 1ns / 1ps

module dedup_deadline_relay_gate_test;
	import ddrg_pkg::*;

	localparam int SEEN_DEPTH = 20;
	localparam int ID_POOL = 24;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 2'd3;

	class relay_gate_tracker;
		logic [63:0] seen_hi [SEEN_DEPTH];
		logic [63:0] seen_lo [SEEN_DEPTH];
		logic        seen_ok [SEEN_DEPTH];
		int          ring_at;
		logic        window_open;
		logic [31:0] close_at;
		logic [31:0] ms_count;
		logic [63:0] window_tag;
		logic [31:0] default_span;
		logic        active_low;
		result_t     pending_outcomes [$];
		int          fails;
		int          matched;

		function new();
			for (int k = 0; k < SEEN_DEPTH; k++) begin
				seen_hi[k] = '0;
				seen_lo[k] = '0;
				seen_ok[k] = 1'b0;
			end
			ring_at = 0;
			window_open = 1'b0;
			close_at = '0;
			ms_count = '0;
			window_tag = '0;
			default_span = DEFAULT_DURATION_RESET;
			active_low = 1'b0;
			fails = 0;
			matched = 0;
		endfunction

		function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_DEFAULT_DURATION: default_span = val;
				REG_RELAY_ACTIVE_LOW: active_low = val[0];
				default: ;
			endcase
		endfunction

		function result_t outcome_of(item_t it);
			result_t     r;
			logic [31:0] left;
			logic [31:0] span;
			logic        hit;
			logic        expired;
			r = '0;
			r.event_res = EV_NONE;
			if (it.cmd == CMD_TICK) begin
				ms_count = ms_count + 32'd1;
				left = ms_count - close_at;
				if (window_open && !left[31]) begin
					window_open = 1'b0;
					r.event_res = EV_TIMEOUT;
					r.event_tag = window_tag;
				end
			end else begin
				hit = 1'b0;
				if (it.msg_id_present) begin
					for (int k = 0; k < SEEN_DEPTH; k++) begin
						if (seen_ok[k] && seen_hi[k] == it.msg_id_high
								&& seen_lo[k] == it.msg_id_low)
							hit = 1'b1;
					end
				end
				if (hit) begin
					r.event_res = EV_DUPLICATE;
				end else begin
					seen_ok[ring_at] = it.msg_id_present;
					seen_hi[ring_at] = it.msg_id_present ? it.msg_id_high : 64'd0;
					seen_lo[ring_at] = it.msg_id_present ? it.msg_id_low : 64'd0;
					ring_at = (ring_at == SEEN_DEPTH - 1) ? 0 : ring_at + 1;
					expired = 1'b0;
					if (it.deadline_present) begin
						if (it.deadline_epoch == 32'd0 || it.now_epoch <= CLOCK_SYNC_EPOCH)
							r.deadline_unchecked = 1'b1;
						else if (it.deadline_epoch < it.now_epoch)
							expired = 1'b1;
					end
					if (expired) begin
						r.event_res = EV_EXPIRED;
					end else begin
						span = it.duration_present ? it.duration_ms : default_span;
						window_open = 1'b1;
						close_at = ms_count + span;
						window_tag = it.verification_tag;
						r.event_res = EV_RELEASED;
						r.event_tag = it.verification_tag;
					end
				end
			end
			r.lamp_on = window_open;
			r.relay_level = window_open ^ active_low;
			return r;
		endfunction

		function void take_item(item_t it);
			pending_outcomes.push_back(outcome_of(it));
		endfunction

		function int outstanding();
			return pending_outcomes.size();
		endfunction

		task report(string what);
			fails++;
			if (fails <= 40)
				$display("mismatch at %0t ns, result %0d: %s", $time, matched, what);
		endtask

		task match_result(result_t got);
			result_t want;
			if (pending_outcomes.size() == 0) begin
				report("result with no transaction outstanding");
				return;
			end
			want = pending_outcomes.pop_front();
			if (got.event_res !== want.event_res)
				report($sformatf("event_res got %0d want %0d", got.event_res, want.event_res));
			if (got.relay_level !== want.relay_level)
				report($sformatf("relay_level got %b want %b", got.relay_level,
					want.relay_level));
			if (got.lamp_on !== want.lamp_on)
				report($sformatf("lamp_on got %b want %b", got.lamp_on, want.lamp_on));
			if (got.event_tag !== want.event_tag)
				report($sformatf("event_tag got %h want %h", got.event_tag, want.event_tag));
			if (got.deadline_unchecked !== want.deadline_unchecked)
				report($sformatf("deadline_unchecked got %b want %b", got.deadline_unchecked,
					want.deadline_unchecked));
			matched++;
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   start;
	logic                   busy;
	item_t                  item;
	logic                   done;
	result_t                result;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	relay_gate_tracker board = new();
	logic [127:0] id_pool [ID_POOL];

	dedup_deadline_relay_gate #(
		.SEEN_DEPTH(SEEN_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.match_result(result);
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic item_t blank_release();
		item_t it;
		it.cmd = CMD_RELEASE;
		it.msg_id_high = rand64();
		it.msg_id_low = rand64();
		it.msg_id_present = 1'b0;
		it.deadline_present = 1'b0;
		it.deadline_epoch = $urandom;
		it.now_epoch = $urandom;
		it.duration_present = 1'b0;
		it.duration_ms = $urandom;
		it.verification_tag = rand64();
		return it;
	endfunction

	function automatic item_t tick_item();
		item_t it;
		it = blank_release();
		it.cmd = CMD_TICK;
		it.msg_id_present = 1'($urandom_range(1));
		it.deadline_present = 1'($urandom_range(1));
		it.duration_present = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic item_t random_release();
		item_t it;
		int    roll;
		int    pick;
		it = blank_release();
		roll = $urandom_range(99);
		pick = $urandom_range(ID_POOL - 1);
		if (roll >= 10) begin
			it.msg_id_present = 1'b1;
			if (roll < 60)
				{it.msg_id_high, it.msg_id_low} = id_pool[pick];
			else if (roll < 68)
				it.msg_id_high = id_pool[pick][127:64];
			else if (roll < 76)
				it.msg_id_low = id_pool[pick][63:0];
		end
		if ($urandom_range(99) < 55) begin
			it.deadline_present = 1'b1;
			roll = $urandom_range(99);
			if (roll < 20)
				it.now_epoch = CLOCK_SYNC_EPOCH + $urandom_range(1);
			else if (roll >= 35)
				it.now_epoch = CLOCK_SYNC_EPOCH + 32'd1 + ($urandom % 32'd2594967295);
			roll = $urandom_range(99);
			if (roll < 15)
				it.deadline_epoch = 32'd0;
			else if (roll < 40)
				it.deadline_epoch = it.now_epoch - $urandom_range(1, 1000);
			else if (roll < 55)
				it.deadline_epoch = it.now_epoch;
			else if (roll < 75)
				it.deadline_epoch = it.now_epoch + $urandom_range(1, 1000);
		end
		if ($urandom_range(99) < 75) begin
			it.duration_present = 1'b1;
			roll = $urandom_range(99);
			if (roll < 60)
				it.duration_ms = $urandom_range(0, 40);
			else if (roll < 70)
				it.duration_ms = 32'd0;
			else if (roll < 80)
				it.duration_ms = 32'h8000_0000 | $urandom;
		end
		return it;
	endfunction

	task automatic drive_item(input item_t it);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.take_item(it);
	endtask

	task automatic gap_before_item(input bit idling);
		if (idling && $urandom_range(99) < 28) begin
			start <= 1'b0;
			repeat ($urandom_range(1, SEEN_DEPTH + 6))
				@(posedge clk);
		end
	endtask

	task automatic send(input item_t it, input bit idling);
		gap_before_item(idling);
		drive_item(it);
	endtask

	task automatic drain_and_settle();
		start <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SEEN_DEPTH + 6)
			@(posedge clk);
	endtask

	task automatic write_registers(input logic [31:0] span, input logic low);
		cfg_we <= 1'b1;
		cfg_index <= REG_DEFAULT_DURATION;
		cfg_wdata <= span;
		board.set_register(REG_DEFAULT_DURATION, span);
		@(posedge clk);
		cfg_index <= REG_RELAY_ACTIVE_LOW;
		cfg_wdata <= {$urandom} & 32'hFFFF_FFFE | {31'd0, low};
		board.set_register(REG_RELAY_ACTIVE_LOW, {31'd0, low});
		@(posedge clk);
		cfg_index <= REG_UNMAPPED_LO;
		cfg_wdata <= $urandom;
		@(posedge clk);
		cfg_index <= REG_UNMAPPED_HI;
		cfg_wdata <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int count, input bit idling);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 50)
				send(tick_item(), idling);
			else
				send(random_release(), idling);
		end
	endtask

	task automatic run_directed();
		item_t it;
		it = blank_release();
		it.verification_tag = '1;
		send(it, 1'b1);
		it = blank_release();
		it.msg_id_present = 1'b1;
		it.msg_id_high = '1;
		it.msg_id_low = '0;
		it.duration_present = 1'b1;
		it.duration_ms = 32'd2;
		it.verification_tag = '0;
		send(it, 1'b1);
		it.verification_tag = rand64();
		send(it, 1'b1);
		repeat (3)
			send(tick_item(), 1'b1);
		it = blank_release();
		it.msg_id_present = 1'b1;
		it.msg_id_high = '0;
		it.msg_id_low = '1;
		it.deadline_present = 1'b1;
		it.deadline_epoch = 32'd0;
		it.now_epoch = CLOCK_SYNC_EPOCH + 32'd50;
		it.duration_present = 1'b1;
		it.duration_ms = 32'd0;
		send(it, 1'b1);
		send(tick_item(), 1'b1);
		it = blank_release();
		it.msg_id_present = 1'b1;
		it.deadline_present = 1'b1;
		it.deadline_epoch = 32'd5;
		it.now_epoch = CLOCK_SYNC_EPOCH;
		it.duration_present = 1'b1;
		it.duration_ms = 32'h8000_0000;
		send(it, 1'b1);
		send(tick_item(), 1'b1);
		it = blank_release();
		it.msg_id_present = 1'b1;
		it.deadline_present = 1'b1;
		it.now_epoch = CLOCK_SYNC_EPOCH + 32'd1;
		it.deadline_epoch = CLOCK_SYNC_EPOCH;
		send(it, 1'b1);
		it.verification_tag = rand64();
		send(it, 1'b1);
		it = blank_release();
		it.msg_id_present = 1'b1;
		it.deadline_present = 1'b1;
		it.now_epoch = '1;
		it.deadline_epoch = '1;
		it.duration_present = 1'b1;
		it.duration_ms = '1;
		send(it, 1'b1);
		it = blank_release();
		it.msg_id_present = 1'b1;
		it.deadline_present = 1'b1;
		it.now_epoch = CLOCK_SYNC_EPOCH + 32'd1;
		it.deadline_epoch = '1;
		it.duration_present = 1'b1;
		it.duration_ms = 32'd5;
		send(it, 1'b1);
		it.msg_id_present = 1'b0;
		it.duration_ms = 32'd1;
		send(it, 1'b1);
		send(it, 1'b1);
		it = blank_release();
		it.msg_id_present = 1'b1;
		it.msg_id_high = '0;
		it.msg_id_low = '0;
		send(it, 1'b1);
		send(it, 1'b1);
		send(tick_item(), 1'b1);
		it = blank_release();
		it.msg_id_present = 1'b1;
		it.msg_id_high = '1;
		it.duration_present = 1'b1;
		it.duration_ms = 32'd1;
		send(it, 1'b1);
		send(tick_item(), 1'b1);
	endtask

	initial begin
		int waited;
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		for (int k = 0; k < ID_POOL; k++)
			id_pool[k] = {rand64(), rand64()};
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(180, 1'b1);
		drain_and_settle();
		write_registers(32'd0, 1'b1);
		run_random(220, 1'b1);
		drain_and_settle();
		write_registers(32'hFFFF_FFFF, 1'b0);
		run_random(300, 1'b0);
		drain_and_settle();
		write_registers($urandom_range(1, 40), 1'b1);
		run_random(250, 1'b1);
		drain_and_settle();
		write_registers($urandom, 1'b0);
		run_random(220, 1'b1);
		drain_and_settle();
		write_registers($urandom_range(0, 30), 1'($urandom_range(1)));
		run_random(200, 1'b1);

		start <= 1'b0;
		waited = 0;
		while (board.outstanding() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SEEN_DEPTH + 8)
			@(posedge clk);
		if (board.outstanding() != 0)
			board.report("transactions left without a result");
		if (board.fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
